// File: sv/mcfp_pkg.sv
// shared types, codes and the command argument table of the marker command frame parser
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

    typedef enum logic [1:0] {
        ST_ARG      = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    localparam logic        OP_BYTE      = 1'b0;
    localparam logic        OP_TICK      = 1'b1;
    localparam logic [7:0]  ESCAPE_CODE  = 8'd69;
    localparam logic [7:0]  LAST_KNOWN   = 8'd10;
    localparam logic [31:0] MARKER_RESET = 32'h4E4F_4445;
    localparam logic [15:0] LIMIT_RESET  = 16'd1000;
    localparam logic [16:0] TICKS_MAX    = 17'h1_FFFF;

    localparam int unsigned CFG_MARKER_WORD   = 0;
    localparam int unsigned CFG_TIMEOUT_LIMIT = 1;

    // number of argument bytes that follow a command code
    function automatic logic [5:0] arg_count(input logic [7:0] code);
        logic [5:0] n;
        case (code)
            8'd0:    n = 6'd1;
            8'd2:    n = 6'd6;
            8'd3:    n = 6'd45;
            8'd7:    n = 6'd8;
            8'd8:    n = 6'd3;
            8'd9:    n = 6'd1;
            default: n = 6'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/marker_command_frame_parser.sv
// marker command frame parser: marker hunt, command decode, argument collection, timeout
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------------------------
//   s_*      | in        | tdata: rx_byte; tuser: operation (0 byte, 1 tick)
//   m_*      | out       | tdata: command_code, arg_index, arg_value; tuser: status,
//            |           | has_arg; tlast: last
//   cfg_*    | in        | write of marker_word (index 0) or timeout_limit (index 1)
//
// one transaction per cycle while s_tready is high; each byte or tick is decoded in the cycle
// it is accepted, and its result (if any) is clocked straight into the output register
// s_tready is high whenever the output register is empty or being drained
// a stall on m_tready holds one result and stops input only while it is full
// aresetn is synchronous; it clears the parser state and restores the register defaults
`timescale 1ns / 1ps
`default_nettype none

module marker_command_frame_parser #(
    parameter int MARKER_LEN = 4
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire  [0:0]  s_tuser,    // [0] operation

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // [7:0] command_code, [13:8] arg_index, [21:14] arg_value
    output logic [2:0]  m_tuser,    // [1:0] status, [2] has_arg
    output logic        m_tlast,

    input  wire         cfg_wr_en,
    input  wire  [0:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata
);

    localparam int MATCH_W = (MARKER_LEN > 4) ? $clog2(MARKER_LEN) : 2;
    localparam logic [MATCH_W:0] MATCH_DONE = (MATCH_W + 1)'(MARKER_LEN);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MARKER = 3'd1,
        PH_CODE   = 3'd2,
        PH_ESCAPE = 3'd3,
        PH_ARGS   = 3'd4
    } phase_t;

    logic [31:0]        marker_reg;
    logic [15:0]        limit_reg;

    phase_t             phase_reg, phase_next;
    logic [MATCH_W-1:0] match_reg, match_next;
    logic [16:0]        ticks_reg, ticks_next;
    logic [7:0]         code_reg, code_next;
    logic [5:0]         left_reg, left_next;
    logic [5:0]         pos_reg, pos_next;

    logic               out_valid_reg, out_valid_next;
    mcfp_pkg::status_t  out_status_reg, res_status;
    logic [7:0]         out_code_reg, res_code;
    logic [5:0]         out_index_reg, res_index;
    logic [7:0]         out_value_reg, res_value;
    logic               out_has_reg, res_has;
    logic               out_last_reg, res_last;
    logic               res_valid;

    logic               accept;
    logic [7:0]         folded;
    logic [7:0]         want_char;
    logic [4:0]         char_shift;
    logic [16:0]        ticks_inc;
    logic [5:0]         code_args;
    logic [MATCH_W-1:0] match_cur;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign folded = (s_tdata >= 8'h61 && s_tdata <= 8'h7A) ? (s_tdata - 8'h20) : s_tdata;

    // a byte in idle starts the hunt at the first marker character
    assign match_cur = (phase_reg == PH_IDLE) ? '0 : match_reg;

    // marker character i comes from byte (i mod 4), counted from the top
    assign char_shift = 5'd24 - {match_cur[1:0], 3'b000};
    assign want_char  = 8'(marker_reg >> char_shift);

    assign ticks_inc = (ticks_reg < mcfp_pkg::TICKS_MAX) ? (ticks_reg + 17'd1) : ticks_reg;
    assign code_args = mcfp_pkg::arg_count(s_tdata);

    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        ticks_next = ticks_reg;
        code_next  = code_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res_status = mcfp_pkg::ST_ARG;
        res_code   = code_reg;
        res_index  = 6'd0;
        res_value  = 8'd0;
        res_has    = 1'b0;
        res_last   = 1'b1;
        if (s_tuser[0] == mcfp_pkg::OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                ticks_next = ticks_inc;
                if (ticks_inc > {1'b0, limit_reg}) begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = mcfp_pkg::ST_TIMEOUT;
                end
            end
        end else begin
            case (phase_reg)
                PH_IDLE, PH_MARKER: begin
                    // a byte in idle opens the frame and is the first marker candidate
                    if (phase_reg == PH_IDLE) begin
                        ticks_next = 17'd0;
                        code_next  = 8'd0;
                        left_next  = 6'd0;
                        pos_next   = 6'd0;
                    end
                    phase_next = PH_MARKER;
                    if (folded == want_char) begin
                        if ({1'b0, match_cur} + 1'b1 >= MATCH_DONE) begin
                            match_next = '0;
                            phase_next = PH_CODE;
                        end else begin
                            match_next = match_cur + 1'b1;
                        end
                    end else begin
                        match_next = '0;
                    end
                end
                PH_CODE, PH_ESCAPE: begin
                    code_next = s_tdata;
                    res_code  = s_tdata;
                    if (phase_reg == PH_CODE && s_tdata == mcfp_pkg::ESCAPE_CODE) begin
                        phase_next = PH_ESCAPE;
                    end else if (s_tdata > mcfp_pkg::LAST_KNOWN) begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = mcfp_pkg::ST_UNKNOWN;
                    end else if (code_args == 6'd0) begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = mcfp_pkg::ST_COMPLETE;
                    end else begin
                        left_next  = code_args;
                        pos_next   = 6'd0;
                        phase_next = PH_ARGS;
                    end
                end
                PH_ARGS: begin
                    res_valid = 1'b1;
                    res_index = pos_reg;
                    res_value = s_tdata;
                    res_has   = 1'b1;
                    res_last  = (left_reg <= 6'd1);
                    pos_next  = pos_reg + 6'd1;
                    if (left_reg <= 6'd1) begin
                        left_next  = 6'd0;
                        phase_next = PH_IDLE;
                    end else begin
                        left_next  = left_reg - 6'd1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign out_valid_next = (accept && res_valid) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg    <= mcfp_pkg::MARKER_RESET;
            limit_reg     <= mcfp_pkg::LIMIT_RESET;
            phase_reg     <= PH_IDLE;
            match_reg     <= '0;
            ticks_reg     <= 17'd0;
            code_reg      <= 8'd0;
            left_reg      <= 6'd0;
            pos_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == 1'(mcfp_pkg::CFG_MARKER_WORD)) begin
                    marker_reg <= cfg_wdata;
                end else begin
                    limit_reg  <= cfg_wdata[15:0];
                end
            end
            if (accept) begin
                phase_reg <= phase_next;
                match_reg <= match_next;
                ticks_reg <= ticks_next;
                code_reg  <= code_next;
                left_reg  <= left_next;
                pos_reg   <= pos_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with a new transaction
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_status_reg <= res_status;
            out_code_reg   <= res_code;
            out_index_reg  <= res_index;
            out_value_reg  <= res_value;
            out_has_reg    <= res_has;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_index_reg, out_code_reg};
    assign m_tuser  = {out_has_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: sv/mcfp_checker.sv
// port-level checks for the marker command frame parser and their bind
`timescale 1ns / 1ps
`default_nettype none

module mcfp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // input is taken whenever the output register has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // only argument bytes carry an argument, and non-argument results close the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == mcfp_pkg::ST_ARG))
            && (m_tuser[1:0] == mcfp_pkg::ST_ARG || (m_tlast && m_tdata[21:8] == 14'd0)))
        else $error("result fields inconsistent with status");

    // argument index stays within the longest argument list
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == mcfp_pkg::ST_ARG |-> m_tdata[13:8] <= 6'd44)
        else $error("argument index out of range");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind marker_command_frame_parser mcfp_checker u_mcfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
